// ===== sv/cgct_pkg.sv =====
// shared types and codes for the call-graph count table
`default_nettype none

package cgct_pkg;

  // item function codes
  localparam logic FUNC_CALL = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } cgct_state_t;

  // control broadcast into one slot cell
  typedef struct packed {
    logic compare;
    logic insert;
    logic row_sel;
  } cgct_cell_ctrl_t;

  // match flags registered inside one slot cell
  typedef struct packed {
    logic callee_hit;
    logic caller_hit;
    logic row_hit;
  } cgct_cell_stat_t;

endpackage

`default_nettype wire

// ===== sv/cgct_cell.sv =====
// one slot cell: holds one function address and matches the broadcast keys
`default_nettype none

module cgct_cell #(
  parameter int ADDR_W = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cgct_pkg::cgct_cell_ctrl_t ctrl,
  input  wire logic [ADDR_W-1:0]         cmp_callee,
  input  wire logic [ADDR_W-1:0]         cmp_caller,
  input  wire logic [ADDR_W-1:0]         ins_addr,
  input  wire logic                      occ_in,
  output logic                           occ_out,
  output cgct_pkg::cgct_cell_stat_t      stat,
  output logic [ADDR_W-1:0]              rd_data
);
  import cgct_pkg::*;

  logic              occupied;
  logic [ADDR_W-1:0] addr;

  // the first free cell after an occupied neighbour takes the new address
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (ctrl.insert && occ_in && !occupied) begin
      occupied <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && occ_in && !occupied) begin
      addr <= ins_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else if (ctrl.compare) begin
      stat.callee_hit <= occupied && (addr == cmp_callee);
      stat.caller_hit <= occupied && (addr == cmp_caller);
      stat.row_hit    <= occupied && ctrl.row_sel;
    end
  end

  assign occ_out = occupied;
  assign rd_data = stat.row_hit ? addr : '0;

endmodule

`default_nettype wire

// ===== sv/cgct_count_ram.sv =====
// pair counter memory, one write and one registered read port
`default_nettype none

module cgct_count_ram #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/call_graph_count_table_unit.sv =====
// call-graph count table: slot cell chain, pair counter memory and control
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------------------------------------
//   in      | to unit   | in_valid/in_stall | func, callee_address, caller_valid,
//           |           |                   | caller_address, read_row, read_col
//   out     | from unit | out_valid/out_stall | callee_slot, is_new, table_full,
//           |           |                   | lookup_error, pair_count, row_address,
//           |           |                   | entries_used
//
// each item passes accept (cells match both keys), lookup (hit encode, slot insert,
// counter read) and update (saturating increment, write back, result out) in turn;
// the registered cell match and counter read divide the steps, and no new item is taken until update is done
// after reset a clearing pass zeroes all TABLE_SLOTS*TABLE_SLOTS counters
// (4096 by default), with in_stall held high
// a finished result waits in the output register while the next item is taken;
// the update stage holds only when that register is still full and stalled
`default_nettype none

module call_graph_count_table_unit #(
  parameter int TABLE_SLOTS  = 64,
  parameter int ADDRESS_BITS = 32,
  parameter int COUNT_BITS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [31:0] callee_address,
  input  wire logic        caller_valid,
  input  wire logic [31:0] caller_address,
  input  wire logic [5:0]  read_row,
  input  wire logic [5:0]  read_col,
  // result item channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       callee_slot,
  output logic             is_new,
  output logic             table_full,
  output logic             lookup_error,
  output logic [31:0]      pair_count,
  output logic [31:0]      row_address,
  output logic [6:0]       entries_used
);
  import cgct_pkg::*;

  localparam int AW     = ADDRESS_BITS;
  localparam int CW     = COUNT_BITS;
  localparam int SW     = $clog2(TABLE_SLOTS);
  localparam int FW     = $clog2(TABLE_SLOTS + 1);
  localparam int CELLS  = TABLE_SLOTS * TABLE_SLOTS;
  localparam int CAW    = $clog2(CELLS);
  localparam logic [CAW-1:0] CLR_LAST = CAW'(CELLS - 1);
  localparam logic [FW-1:0]  FILL_MAX = FW'(TABLE_SLOTS);

  // control state
  cgct_state_t    state, state_next;
  logic [CAW-1:0] clr_addr;
  logic [FW-1:0]  fill;

  // item held for the lookup
  logic           func_r;
  logic [AW-1:0]  callee_r;
  logic           caller_valid_r;
  logic [AW-1:0]  caller_r;
  logic [5:0]     row_r;
  logic [5:0]     col_r;

  // lookup results held for the update
  logic [SW-1:0]  res_slot;
  logic           res_new;
  logic           res_full;
  logic           res_err;
  logic           count_en;
  logic           rd_ok;
  logic [CAW-1:0] cnt_addr;

  // fsm outputs
  logic accept;
  logic do_lookup;
  logic do_update;
  logic ram_we;
  logic ram_re;

  // cell chain wiring
  cgct_cell_ctrl_t cell_ctrl [TABLE_SLOTS];
  cgct_cell_stat_t cell_stat [TABLE_SLOTS];
  logic [AW-1:0]   cell_rd   [TABLE_SLOTS];
  logic [TABLE_SLOTS:0] occ;

  logic [AW-1:0] in_callee;
  logic [AW-1:0] in_caller;

  // lookup datapath
  logic [TABLE_SLOTS-1:0] callee_hits;
  logic [SW-1:0]  callee_idx, caller_idx, cs, rs;
  logic           callee_found, caller_found;
  logic           callee_zero, caller_zero, room;
  logic           do_insert, callee_ok, caller_ok;
  logic           lk_err, lk_full, lk_count, lk_rd_ok;
  logic [CAW-1:0] lk_addr;

  // update datapath
  logic [CW-1:0]  ram_rdata;
  logic [CW-1:0]  sat_count;
  logic [CW-1:0]  new_count;
  logic [AW-1:0]  row_gather;
  logic [CAW-1:0] ram_waddr;
  logic [CW-1:0]  ram_wdata;

  assign in_callee = AW'(callee_address);
  assign in_caller = AW'(caller_address);

  // ---------------------------------------------------------------------------
  // control: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // control: outputs
  always_comb begin
    in_stall  = 1'b1;
    do_lookup = 1'b0;
    do_update = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_LOOKUP: begin
        do_lookup = 1'b1;
        ram_re    = 1'b1;
      end
      ST_UPDATE: begin
        do_update = !out_valid || !out_stall;
        ram_we    = do_update && (func_r == FUNC_CALL) && count_en;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // held item fields
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r         <= func;
      callee_r       <= in_callee;
      caller_valid_r <= caller_valid;
      caller_r       <= in_caller;
      row_r          <= read_row;
      col_r          <= read_col;
    end
  end

  // ---------------------------------------------------------------------------
  // slot cell chain; occupancy passes from each cell to the next so that the
  // first free cell knows it is the insertion point
  // ---------------------------------------------------------------------------
  assign occ[0] = 1'b1;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].compare = accept;
      cell_ctrl[i].insert  = do_lookup && do_insert;
      cell_ctrl[i].row_sel = (int'(read_row) == i);
    end

    cgct_cell #(
      .ADDR_W (AW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl[i]),
      .cmp_callee (in_callee),
      .cmp_caller (in_caller),
      .ins_addr   (callee_r),
      .occ_in     (occ[i]),
      .occ_out    (occ[i+1]),
      .stat       (cell_stat[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // encode the registered hit flags (at most one set per key) and gather the
  // selected row's address
  always_comb begin
    callee_hits  = '0;
    callee_idx   = '0;
    caller_idx   = '0;
    callee_found = 1'b0;
    caller_found = 1'b0;
    row_gather   = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      callee_hits[i] = cell_stat[i].callee_hit;
      if (cell_stat[i].callee_hit) begin
        callee_idx   = callee_idx | SW'(i);
        callee_found = 1'b1;
      end
      if (cell_stat[i].caller_hit) begin
        caller_idx   = caller_idx | SW'(i);
        caller_found = 1'b1;
      end
      row_gather = row_gather | cell_rd[i];
    end
  end

  // ---------------------------------------------------------------------------
  // lookup: insertion decision, caller resolution and counter address
  // ---------------------------------------------------------------------------
  always_comb begin
    callee_zero = (callee_r == '0);
    caller_zero = (caller_r == '0);
    room        = (fill != FILL_MAX);
    do_insert   = (func_r == FUNC_CALL) && !callee_zero && !callee_found && room;
    callee_ok   = !callee_zero && (callee_found || room);
    lk_full     = !callee_zero && !callee_found && !room;
    cs          = callee_found ? callee_idx : SW'(fill);
    // a recursive call finds the callee it has just inserted
    caller_ok   = !caller_zero && (caller_found || (do_insert && (caller_r == callee_r)));
    rs          = caller_found ? caller_idx : cs;
    lk_err      = callee_zero || (caller_valid_r && !caller_ok);
    lk_count    = caller_valid_r && caller_ok && callee_ok;
    lk_rd_ok    = (int'(row_r) < TABLE_SLOTS) && (int'(col_r) < TABLE_SLOTS);
    if (func_r == FUNC_READ) begin
      lk_addr = CAW'(SW'(row_r)) * CAW'(TABLE_SLOTS) + CAW'(SW'(col_r));
    end else begin
      lk_addr = CAW'(rs) * CAW'(TABLE_SLOTS) + CAW'(cs);
    end
  end

  always_ff @(posedge clk) begin
    if (do_lookup) begin
      res_slot <= ((func_r == FUNC_CALL) && callee_ok) ? cs : '0;
      res_new  <= do_insert;
      res_full <= (func_r == FUNC_CALL) && lk_full;
      res_err  <= (func_r == FUNC_CALL) && lk_err;
      count_en <= lk_count;
      rd_ok    <= lk_rd_ok;
      cnt_addr <= lk_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (do_lookup && do_insert) begin
      fill <= fill + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // counter memory and saturating update
  // ---------------------------------------------------------------------------
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : cnt_addr;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : sat_count;

  cgct_count_ram #(
    .DEPTH  (CELLS),
    .DATA_W (CW),
    .ADDR_W (CAW)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (lk_addr),
    .rdata (ram_rdata)
  );

  // counter stops at its maximum
  assign sat_count = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

  always_comb begin
    if (func_r == FUNC_READ) begin
      new_count = rd_ok ? ram_rdata : '0;
    end else begin
      new_count = count_en ? sat_count : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      callee_slot  <= 6'(res_slot);
      is_new       <= res_new;
      table_full   <= res_full;
      lookup_error <= res_err;
      pair_count   <= 32'(new_count);
      row_address  <= (func_r == FUNC_READ) ? 32'(row_gather) : 32'd0;
      entries_used <= 7'(fill);
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // table entries are distinct, so a key hits at most one cell
  a_callee_unique: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |-> $onehot0(callee_hits))
    else $error("callee address matched in more than one cell");

  // the occupancy chain and the fill count agree
  a_fill_matches_chain: assert property (@(posedge clk) disable iff (rst)
    $countones(occ[TABLE_SLOTS:1]) == int'(fill))
    else $error("cell occupancy disagrees with fill count");

  // an insertion always grows the fill count by one
  a_insert_grows_fill: assert property (@(posedge clk) disable iff (rst)
    (do_lookup && do_insert) |=> (fill == $past(fill) + 1'b1))
    else $error("insertion did not advance fill count");

  // a new callee never comes with a full table
  a_new_not_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_new) |-> !table_full)
    else $error("result flags both new and full");

endmodule

`default_nettype wire
